// File: design/tbrc_pkg.sv
`timescale 1ns / 1ps
package tbrc_pkg;

    typedef enum logic [2:0] {
        OP_SPEED   = 3'd0,
        OP_LATENCY = 3'd1,
        OP_TURN    = 3'd2,
        OP_FRAME   = 3'd3,
        OP_ANALYZE = 3'd4
    } t_op;

    localparam logic [1:0] REG_CONTROL_ENABLE = 2'd0;
    localparam logic [1:0] REG_HOST_MODE      = 2'd1;
    localparam logic [1:0] REG_HUMAN_MASK     = 2'd2;
    localparam logic [1:0] REG_OVERHEAD_MS    = 2'd3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [7:0]  GRAN_RESET   = 8'h5A;
    localparam logic [4:0]  FRAMES_RESET = 5'd10;
    localparam logic [12:0] LAT_MIN      = 13'h1E;
    localparam logic [12:0] LAT_MAX      = 13'd6000;
    localparam logic [7:0]  GRAN_MAX     = 8'h96;
    localparam logic [8:0]  BUF_MIN      = 9'hFA;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  peer;
        logic [7:0]  avg_frame_ms;
        logic [7:0]  hi_lat_tens;
        logic [15:0] latency_ms;
        logic [31:0] turn_no;
        logic [7:0]  turn_increment;
        logic        apply;
        logic [15:0] frame_number;
        logic [15:0] turn_elapsed_ms;
    } t_in;

    typedef struct packed {
        logic [7:0]  grant_ms;
        logic        changed;
        logic [7:0]  new_granularity;
        logic [4:0]  new_frame_cnt;
        logic        send_change;
        logic [4:0]  frames_left;
        logic [31:0] dropped_total;
        logic [31:0] adjust_total;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_SCAN, ST_GRAN, ST_DIV1, ST_FR1, ST_DIV2, ST_FR2,
        ST_FIN, ST_OUT
    } t_state;

endpackage

// File: design/tbrc_div.sv
`timescale 1ns / 1ps
module tbrc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_num,
    input  logic [7:0]  i_den,
    output logic        o_done,
    output logic [11:0] o_quo
);
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic [11:0] r_q;
    logic [8:0]  r_rem;
    logic [7:0]  r_den;
    logic [8:0]  n_rem;

    assign n_rem = {r_rem[7:0], r_q[11]};
    assign o_quo = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_rem >= {1'b0, r_den}) begin
                    r_rem <= n_rem - {1'b0, r_den};
                    r_q   <= {r_q[10:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[10:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd11) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: design/turn_buffer_rate_controller.sv
`timescale 1ns / 1ps
// turn buffer rate controller
// input channel: one op beat (speed report, latency report, turn start, frame,
// analyze) in i_in_data with i_in_valid / o_in_ready. output channel: exactly
// one result beat per input beat on o_out_data with o_out_valid / i_out_ready.
// configuration: i_cfg_we, i_cfg_idx, i_cfg_data, to be written by the user
// only when the block idles (not enforced by it). one beat at a time. report,
// turn start, frame and unused ops pass ST_READ (update from the table memory
// read) and ST_OUT (output register); no new beat until the result has left.
// analyze scans peer slots one per cycle out of the table memory in ST_SCAN and
// runs up to two restoring divisions in a shared divider through ST_GRAN,
// ST_DIV1, ST_FR1, ST_DIV2 (only when the second division is needed), ST_FR2,
// ST_FIN and ST_OUT; an analyze that does nothing goes straight to ST_OUT.
// the result register holds its beat while the receiver stalls; the next input
// beat is taken only once that result leaves.
// reset restores granularity 90, 10 frames per turn, counters zero, latency 30
// and zero frame and high-latency entries: the table is held in memory with one
// valid bit per slot, so no clearing pass is needed.
module turn_buffer_rate_controller #(
    parameter int PEER_SLOTS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tbrc_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tbrc_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [tbrc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tbrc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tbrc_pkg::*;

    localparam int PW = $clog2(PEER_SLOTS);

    logic        r_ctl_en, r_host;
    logic [9:0]  r_human;
    logic [15:0] r_ovh;

    // peer table memory: {latency, frame_ms, high_latency}
    logic [32:0] r_mem [PEER_SLOTS];
    logic [PEER_SLOTS-1:0] r_vld;
    logic [32:0] r_rd;
    logic        r_rd_vld;
    logic [PW-1:0] n_raddr;
    logic        n_rd_en;

    t_state      r_st, n_st;
    t_in         r_in;
    t_out        r_out;
    logic        r_ov;

    logic [7:0]  r_gran, r_pgran;
    logic [4:0]  r_frames, r_left, r_pframes;
    logic [31:0] r_cturn, r_adj, r_drop;
    logic [15:0] r_since, r_drop_turn;
    logic [PW:0] r_scan;
    logic [7:0]  r_maxfr;
    logic [11:0] r_maxlat;
    logic [7:0]  r_g;
    logic [4:0]  r_f;
    logic [31:0] r_turn;

    logic        n_dstart, w_ddone;
    logic [11:0] n_dnum, w_dquo;
    logic [7:0]  n_dden;
    logic [7:0]  w_dsel;

    logic [31:0] w_turn;
    logic        w_an_skip;
    logic [4:0]  w_f1;
    logic [12:0] w_prod;

    tbrc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_dstart), .i_num(n_dnum),
        .i_den(n_dden), .o_done(w_ddone), .o_quo(w_dquo)
    );

    logic w_peer_ok;
    assign w_peer_ok = (r_in.peer != 4'd0) && ({1'b0, r_in.peer} < 5'(PEER_SLOTS));
    assign o_in_ready  = (r_st == ST_IDLE) && !r_ov;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign w_turn    = r_in.turn_no + 32'(r_in.turn_increment);
    assign w_an_skip = !r_host || (r_cturn != 32'd0) || (w_turn < 32'd20) ||
                       ({1'b0, r_since} + 17'd1 < 17'd5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_en <= 1'b1;
            r_host   <= 1'b0;
            r_human  <= '0;
            r_ovh    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CONTROL_ENABLE: r_ctl_en <= i_cfg_data[0];
                REG_HOST_MODE:      r_host   <= i_cfg_data[0];
                REG_HUMAN_MASK:     r_human  <= i_cfg_data[9:0];
                REG_OVERHEAD_MS:    r_ovh    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_rd_en = 1'b0;
        n_raddr = '0;
        if (r_st == ST_SCAN && r_scan < (PW+1)'(PEER_SLOTS)) begin
            n_rd_en = 1'b1;
            n_raddr = r_scan[PW-1:0];
        end
    end

    // peer table memory, written only in ST_READ of report ops
    logic        w_mwe;
    logic [32:0] w_mwd;
    logic [12:0] w_lat;
    always_comb begin
        w_lat = (r_in.latency_ms < 16'(LAT_MIN)) ? LAT_MIN :
                (r_in.latency_ms > 16'(LAT_MAX)) ? LAT_MAX : r_in.latency_ms[12:0];
        w_mwe = (r_st == ST_READ) && w_peer_ok &&
                (r_in.op == OP_SPEED || r_in.op == OP_LATENCY);
        w_mwd = r_vld[r_in.peer[PW-1:0]] ? r_rd : {LAT_MIN, 8'd0, 12'd0};
        if (r_in.op == OP_SPEED) begin
            w_mwd[19:0] = {r_in.avg_frame_ms, 12'(r_in.hi_lat_tens * 4'd10)};
        end else begin
            w_mwd[32:20] = w_lat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mwe) r_mem[r_in.peer[PW-1:0]] <= w_mwd;
        if (r_st == ST_IDLE) r_rd <= r_mem[i_in_data.peer[PW-1:0]];
        else if (n_rd_en) r_rd <= r_mem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_mwe) r_vld[r_in.peer[PW-1:0]] <= 1'b1;
            r_rd_vld <= n_rd_en;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_in_valid && o_in_ready) n_st = ST_READ;
            ST_READ: n_st = (r_in.op == OP_ANALYZE && !w_an_skip) ? ST_SCAN : ST_OUT;
            ST_SCAN: if (!n_rd_en && !r_rd_vld) n_st = ST_GRAN;
            ST_GRAN: n_st = ST_DIV1;
            ST_DIV1: if (w_ddone) n_st = ST_FR1;
            ST_FR1:  n_st = (w_prod < 13'(BUF_MIN)) ? ST_DIV2 : ST_FR2;
            ST_DIV2: if (w_ddone) n_st = ST_FR2;
            ST_FR2:  n_st = ST_FIN;
            ST_FIN:  n_st = ST_OUT;
            ST_OUT:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // gran rounding: (max_fr+5)/10*10 via reciprocal
    logic [8:0]  w_rsum;
    logic [17:0] w_rprod;
    logic [4:0]  w_rq;
    logic [8:0]  w_rg;
    logic [7:0]  w_gsel;
    logic [8:0]  w_gd;
    always_comb begin
        w_rsum  = {1'b0, r_maxfr} + 9'd5;
        w_rprod = 18'(w_rsum * 9'd205);
        w_rq    = w_rprod[15:11];
        w_rg    = 9'(w_rq * 4'd10);
        if (w_rg > 9'(GRAN_MAX)) w_rg = 9'(GRAN_MAX);
        w_gd = (w_rg >= {1'b0, r_gran}) ? w_rg - {1'b0, r_gran} : {1'b0, r_gran} - w_rg;
        w_gsel = (w_gd < 9'd10) ? r_gran : w_rg[7:0];
    end

    assign n_dstart = (r_st == ST_GRAN) || (r_st == ST_FR1 && w_prod < 13'(BUF_MIN));
    assign w_dsel   = (r_st == ST_GRAN) ? w_gsel : r_g;
    assign n_dden   = (w_dsel == 8'd0) ? 8'd1 : w_dsel;
    assign n_dnum   = (r_st == ST_GRAN) ? r_maxlat : 12'(BUF_MIN);
    always_comb begin
        w_f1 = (w_dquo > 12'd17) ? 5'd20 : 5'(w_dquo + 12'd2);
        if (w_f1 < 5'd5) w_f1 = 5'd4;
        w_prod = 13'(r_g * r_f);
    end

    logic [12:0] w_nt, w_ct, w_ad;
    always_comb begin
        w_nt = 13'(r_g * r_f);
        w_ct = 13'(r_gran * r_frames);
        w_ad = (w_nt >= w_ct) ? w_nt - w_ct : w_ct - w_nt;
    end

    logic [16:0] w_avail;
    logic [12:0] w_buf;
    assign w_avail = {1'b0, r_ovh} + {1'b0, r_in.turn_elapsed_ms};
    assign w_buf = (r_frames >= r_left) ? 13'((r_frames - r_left) * r_gran) : 13'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
            r_gran <= GRAN_RESET;
            r_frames <= FRAMES_RESET;
            r_left <= '0;
            r_pframes <= '0;
            r_pgran <= '0;
            r_cturn <= '0;
            r_adj <= '0;
            r_since <= '0;
            r_drop <= '0;
            r_drop_turn <= '0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (i_in_valid && o_in_ready) begin
                    r_in <= i_in_data;
                    r_out <= '0;
                end
                ST_READ: begin
                    r_scan <= (PW+1)'(1);
                    r_maxfr <= 8'd10;
                    r_maxlat <= 12'd30;
                    r_turn <= w_turn;
                    case (r_in.op)
                        OP_TURN: begin
                            r_drop_turn <= '0;
                            if (r_cturn != 32'd0) r_since <= '0;
                            if (r_cturn != 32'd0 && r_cturn <= r_in.turn_no) begin
                                r_cturn <= '0;
                                r_adj <= r_adj + 32'd1;
                                r_frames <= r_pframes;
                                r_gran <= r_pgran;
                                r_left <= r_pframes;
                                r_pframes <= '0;
                                r_pgran <= '0;
                            end else begin
                                r_left <= r_frames;
                            end
                        end
                        OP_FRAME: if (r_left != 5'd0) begin
                            if (w_avail < 17'(w_buf)) begin
                                if (r_in.frame_number > 16'd6) begin
                                    r_drop <= r_drop + 32'd1;
                                    r_drop_turn <= r_drop_turn + 16'd1;
                                end
                            end else begin
                                r_left <= r_left - 5'd1;
                                r_out.grant_ms <= r_gran;
                            end
                        end
                        OP_ANALYZE: begin
                            if (r_host && r_cturn == 32'd0 && w_turn >= 32'd20 &&
                                r_since != 16'hFFFF)
                                r_since <= r_since + 16'd1;
                        end
                        default: ;
                    endcase
                end
                ST_SCAN: begin
                    if (n_rd_en) r_scan <= r_scan + (PW+1)'(1);
                    if (r_rd_vld && (PW+1)'(r_scan - 1) < 5'd10 &&
                        r_human[4'(r_scan - 1)] && r_vld[PW'(r_scan - 1)]) begin
                        if (r_maxfr <= r_rd[19:12]) r_maxfr <= r_rd[19:12];
                        if (r_maxlat <= r_rd[11:0]) r_maxlat <= r_rd[11:0];
                    end
                end
                ST_GRAN: r_g <= w_gsel;
                ST_DIV1: if (w_ddone) r_f <= w_f1;
                ST_FR1: ;
                ST_DIV2: if (w_ddone) r_f <= 5'(w_dquo + 12'd1);
                ST_FR2: ;
                ST_FIN: begin
                    if (w_ad >= 13'd11) begin
                        r_out.changed <= 1'b1;
                        r_out.new_granularity <= r_g;
                        r_out.new_frame_cnt <= (w_nt < w_ct && w_ad > 13'd100 &&
                            r_frames > 5'd4) ? r_frames - 5'd1 : r_f;
                        if (r_in.apply && r_ctl_en) begin
                            r_pframes <= (w_nt < w_ct && w_ad > 13'd100 &&
                                r_frames > 5'd4) ? r_frames - 5'd1 : r_f;
                            r_pgran <= r_g;
                            r_cturn <= r_turn;
                            r_out.send_change <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    r_ov <= 1'b1;
                    r_out.frames_left <= r_left;
                    r_out.dropped_total <= r_drop;
                    r_out.adjust_total <= r_adj;
                end
                default: ;
            endcase
        end
    end

    // scan index stays inside the table
    a_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_scan <= (PW+1)'(PEER_SLOTS)))
        else $error("scan index out of range");
    // no new beat while a result is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !o_in_ready)
        else $error("input taken while result pending");
    // a beat always leads to a result through ST_READ
    a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_st == ST_READ))
        else $error("accepted beat not processed");
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import tbrc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    turn_buffer_rate_controller uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted block state
    logic [7:0]  gran_now;
    logic [4:0]  frames_per_turn, credit, pend_frames;
    logic [7:0]  pend_gran;
    logic [31:0] sched_turn, adjust_cnt, drop_cnt;
    logic [15:0] since_adjust, drop_turn;
    logic [7:0]  frame_tab [10];
    logic [11:0] hilat_tab [10];
    logic        cfg_enable, cfg_host;
    logic [9:0]  cfg_human;
    logic [15:0] cfg_overhead;

    t_in  op_q [$];
    t_out result_q [$];
    int   errors = 0;
    int   beats_in = 0, beats_out = 0, changes_seen = 0, grants_seen = 0;
    int   snd_idle = 0, rcv_idle = 0, rcv_hold = 0;
    bit   in_taken = 0;
    logic [31:0] turn_now = 32'd100;

    function automatic t_out predict_result(t_in it);
        t_out r;
        int used, buf_time, mfr, mlat, gran, fr, dv, d, nt, ct, ad;
        bit ok;
        logic [31:0] turn;
        r = '0;
        case (it.op)
            OP_SPEED: if (it.peer != 0 && it.peer < 10) begin
                frame_tab[it.peer] = it.avg_frame_ms;
                hilat_tab[it.peer] = 12'(it.hi_lat_tens * 10);
            end
            OP_TURN: begin
                drop_turn = 16'd0;
                if (sched_turn != 0) begin
                    since_adjust = 16'd0;
                    if (sched_turn <= it.turn_no) begin
                        sched_turn = 32'd0;
                        adjust_cnt = adjust_cnt + 32'd1;
                        frames_per_turn = pend_frames;
                        gran_now = pend_gran;
                        pend_frames = 5'd0;
                        pend_gran = 8'd0;
                    end
                end
                credit = frames_per_turn;
            end
            OP_FRAME: if (credit != 0) begin
                used = (frames_per_turn >= credit) ? int'(frames_per_turn - credit) : 0;
                buf_time = used * int'(gran_now);
                if (int'(cfg_overhead) + int'(it.turn_elapsed_ms) < buf_time) begin
                    if (it.frame_number > 6) begin
                        drop_cnt = drop_cnt + 32'd1;
                        drop_turn = drop_turn + 16'd1;
                    end
                end else begin
                    credit = credit - 5'd1;
                    r.grant_ms = gran_now;
                end
            end
            OP_ANALYZE: begin
                ok = cfg_host && sched_turn == 0;
                turn = it.turn_no + 32'(it.turn_increment);
                if (ok && turn < 20) ok = 0;
                if (ok) begin
                    if (since_adjust < 16'hFFFF) since_adjust = since_adjust + 16'd1;
                    if (since_adjust < 5) ok = 0;
                end
                if (ok) begin
                    mfr = 10;
                    mlat = 30;
                    for (int p = 1; p < 10; p++) begin
                        if (cfg_human[p]) begin
                            if (mfr <= int'(frame_tab[p])) mfr = int'(frame_tab[p]);
                            if (mlat <= int'(hilat_tab[p])) mlat = int'(hilat_tab[p]);
                        end
                    end
                    gran = ((mfr + 5) / 10) * 10;
                    if (gran > 150) gran = 150;
                    d = gran - int'(gran_now);
                    if (d < 10 && d > -10) gran = int'(gran_now);
                    dv = (gran != 0) ? gran : 1;
                    fr = mlat / dv + 2;
                    if (fr > 19) fr = 20;
                    if (fr < 5) fr = 4;
                    if (gran * fr < 250) fr = 250 / dv + 1;
                    nt = gran * fr;
                    ct = int'(frames_per_turn) * int'(gran_now);
                    d = nt - ct;
                    ad = d < 0 ? -d : d;
                    if (ad >= 11) begin
                        if (nt < ct && ad > 100 && frames_per_turn > 4)
                            fr = int'(frames_per_turn) - 1;
                        r.changed = 1'b1;
                        r.new_granularity = gran[7:0];
                        r.new_frame_cnt = fr[4:0];
                        if (it.apply && cfg_enable) begin
                            pend_frames = fr[4:0];
                            pend_gran = gran[7:0];
                            sched_turn = turn;
                            r.send_change = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.frames_left = credit;
        r.dropped_total = drop_cnt;
        r.adjust_total = adjust_cnt;
        return r;
    endfunction

    function automatic t_in make_item(bit noise);
        t_in it;
        int k;
        it = t_in'(112'({$urandom, $urandom, $urandom, $urandom}));
        if (noise) return it;
        it.peer = 4'($urandom_range(1, 9));
        k = $urandom_range(0, 99);
        if (k < 25) begin
            it.op = OP_SPEED;
            it.avg_frame_ms = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 160));
            it.hi_lat_tens = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 60));
        end else if (k < 32) begin
            it.op = OP_LATENCY;
        end else if (k < 45) begin
            it.op = OP_TURN;
            if ($urandom_range(0, 2) != 0) turn_now = turn_now + $urandom_range(0, 4);
            it.turn_no = turn_now;
        end else if (k < 85) begin
            it.op = OP_FRAME;
            it.frame_number = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 12));
            it.turn_elapsed_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 1500));
        end else begin
            it.op = OP_ANALYZE;
            it.turn_no = turn_now;
            it.turn_increment = 8'($urandom_range(0, 6));
            it.apply = $urandom_range(0, 3) != 0;
        end
        return it;
    endfunction

    function automatic t_in mk(t_op op, logic [3:0] peer, logic [7:0] avg, logic [7:0] hic,
                               logic [15:0] lat, logic [31:0] turn, logic [7:0] inc,
                               logic ap, logic [15:0] fno, logic [15:0] el);
        t_in it;
        it = '{op, peer, avg, hic, lat, turn, inc, ap, fno, el};
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_CONTROL_ENABLE: cfg_enable = val[0];
            REG_HOST_MODE:      cfg_host = val[0];
            REG_HUMAN_MASK:     cfg_human = val[9:0];
            default:            cfg_overhead = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (op_q.size() != 0 || result_q.size() != 0 || i_in_valid) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_regs(logic en, logic host, logic [9:0] mask, logic [15:0] ovh);
        write_reg(REG_CONTROL_ENABLE, {15'd0, en});
        write_reg(REG_HOST_MODE, {15'd0, host});
        write_reg(REG_HUMAN_MASK, {6'd0, mask});
        write_reg(REG_OVERHEAD_MS, ovh);
    endtask

    task automatic random_phase(int n, int s_idle, int r_idle);
        snd_idle = s_idle;
        rcv_idle = r_idle;
        for (int i = 0; i < n; i++) op_q.push_back(make_item($urandom_range(0, 9) == 0));
        drain();
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (in_taken || !i_in_valid)) begin
            in_taken = 0;
            if (op_q.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
                i_in_valid <= 1'b1;
                i_in_data <= op_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        if (rcv_hold > 0) begin
            rcv_hold = rcv_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(0, 99) >= rcv_idle;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            result_q.push_back(predict_result(i_in_data));
            in_taken = 1;
            beats_in++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_out++;
            if (result_q.size() == 0) begin
                $display("%0t unexpected beat: actual %p", $time, o_out_data);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (want.changed) changes_seen++;
                if (want.grant_ms != 0) grants_seen++;
                if (o_out_data !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, o_out_data);
                    errors++;
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        gran_now = GRAN_RESET;
        frames_per_turn = FRAMES_RESET;
        credit = 0;
        pend_frames = 0;
        pend_gran = 0;
        sched_turn = 0;
        adjust_cnt = 0;
        since_adjust = 0;
        drop_cnt = 0;
        drop_turn = 0;
        for (int p = 0; p < 10; p++) begin
            frame_tab[p] = 0;
            hilat_tab[p] = 0;
        end
        cfg_enable = 1;
        cfg_host = 0;
        cfg_human = 0;
        cfg_overhead = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: analyze ignored, frames without credit, unused ops
        op_q.push_back(mk(OP_ANALYZE, 4'd1, 8'd0, 8'd0, 16'd0, 32'd500, 8'd5, 1'b1, 16'd0, 16'd0));
        op_q.push_back(mk(OP_FRAME, 4'd0, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 16'd9, 16'd0));
        op_q.push_back(t_in'({3'd5, {109{1'b1}}}));
        op_q.push_back(t_in'({3'd7, 109'd0}));
        drain();
        set_regs(1'b1, 1'b1, 10'h3FE, 16'd0);
        // table edges, ignored slots, latency clamps
        op_q.push_back(mk(OP_SPEED, 4'd0, 8'd255, 8'd255, 16'd0, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
        op_q.push_back(mk(OP_SPEED, 4'd10, 8'd255, 8'd255, 16'd0, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
        op_q.push_back(mk(OP_SPEED, 4'd15, 8'd255, 8'd255, 16'd0, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
        op_q.push_back(mk(OP_SPEED, 4'd9, 8'd255, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
        op_q.push_back(mk(OP_SPEED, 4'd1, 8'd0, 8'd255, 16'd0, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
        op_q.push_back(mk(OP_LATENCY, 4'd2, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
        op_q.push_back(mk(OP_LATENCY, 4'd3, 8'd0, 8'd0, 16'hFFFF, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
        op_q.push_back(mk(OP_LATENCY, 4'd0, 8'd0, 8'd0, 16'd6001, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
        // change turn below 20 and wrapping change turn
        op_q.push_back(mk(OP_ANALYZE, 4'd0, 8'd0, 8'd0, 16'd0, 32'd0, 8'd19, 1'b1, 16'd0, 16'd0));
        op_q.push_back(mk(OP_ANALYZE, 4'd0, 8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF, 8'd255, 1'b1,
                          16'd0, 16'd0));
        for (int i = 0; i < 5; i++)
            op_q.push_back(mk(OP_ANALYZE, 4'd0, 8'd0, 8'd0, 16'd0, 32'd50, 8'd3, 1'b1,
                              16'd0, 16'd0));
        // change already pending, then apply at its turn
        op_q.push_back(mk(OP_ANALYZE, 4'd0, 8'd0, 8'd0, 16'd0, 32'd50, 8'd3, 1'b1, 16'd0, 16'd0));
        op_q.push_back(mk(OP_TURN, 4'd0, 8'd0, 8'd0, 16'd0, 32'd52, 8'd0, 1'b0, 16'd0, 16'd0));
        op_q.push_back(mk(OP_TURN, 4'd0, 8'd0, 8'd0, 16'd0, 32'd53, 8'd0, 1'b0, 16'd0, 16'd0));
        // pacing: granted, refused early, refused and dropped, saturated fields
        op_q.push_back(mk(OP_FRAME, 4'd0, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
        op_q.push_back(mk(OP_FRAME, 4'd0, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 16'd6, 16'd0));
        op_q.push_back(mk(OP_FRAME, 4'd0, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 16'hFFFF, 16'd0));
        op_q.push_back(mk(OP_FRAME, 4'd0, 8'd0, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 16'hFFFF,
                          16'hFFFF));
        drain();

        set_regs(1'b1, 1'b1, 10'h3FF, 16'd0);
        rcv_hold = 600;
        random_phase(700, 31, 83);
        set_regs(1'b0, 1'b1, 10'($urandom), 16'hFFFF);
        random_phase(300, 83, 31);
        set_regs(1'b1, 1'b1, 10'h2AA, 16'($urandom_range(0, 400)));
        random_phase(400, 83, 31);
        set_regs(1'b1, 1'b1, 10'($urandom), 16'd0);
        random_phase(500, 0, 0);
        set_regs(1'b0, 1'b0, 10'd0, 16'($urandom));
        random_phase(150, 0, 0);

        $display("beats in %0d, out %0d: %0d frames granted, %0d speed changes proposed",
                 beats_in, beats_out, grants_seen, changes_seen);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
